>>> design/cdte_pkg.sv
// ----------------------------------------------------------------------------
// cdte_pkg
// Shared constants and controller/datapath command and status types for the
// crossing-retimed dual-tap echo.
// ----------------------------------------------------------------------------
package cdte_pkg;

    localparam int MEMORY_DEPTH_DEF = 65536;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int ENTRY_BITS_DEF   = 24;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_ADDR_BITS-1:0] REG_DECAY_GAIN   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_STEP     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_WRAP  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CROSS_LEVEL  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WET_MIX      = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OUT_VOLUME   = 3'd5;

    localparam int COUNTER_WRAP_OFFSET = 13;
    localparam int RETIME_OFFSET       = 12;

    typedef struct packed {
        logic clear_step;
        logic start;
        logic read_first;
        logic write_first;
        logic advance;
        logic read_second;
        logic write_second;
        logic read_new;
        logic write_new;
        logic mix_a;
        logic mix_b;
        logic finish;
    } cdte_cmd_t;

    typedef struct packed {
        logic clear_done;
    } cdte_status_t;

endpackage

>>> design/cdte_datapath.sv
// ----------------------------------------------------------------------------
// cdte_datapath
// Delay memory, taps, decay, retiming and output mix, stepped by the
// controller's command strobes.
// ----------------------------------------------------------------------------
module cdte_datapath #(
    parameter int MEMORY_DEPTH = cdte_pkg::MEMORY_DEPTH_DEF,
    parameter int SAMPLE_BITS  = cdte_pkg::SAMPLE_BITS_DEF,
    parameter int ENTRY_BITS   = cdte_pkg::ENTRY_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cdte_pkg::cdte_cmd_t                  cmd,
    output cdte_pkg::cdte_status_t               status,
    input  logic                                 wr_en,
    input  logic [cdte_pkg::CFG_ADDR_BITS-1:0]   wr_index,
    input  logic [cdte_pkg::CFG_DATA_BITS-1:0]   wr_data,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic signed [SAMPLE_BITS-1:0]        sample_out
);

    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam int LW = AW + 1;
    localparam int TW = AW + 17;
    localparam int PW = ENTRY_BITS + 18;
    localparam int MW = ENTRY_BITS + 20;
    localparam int VW = MW + 18;
    localparam logic [LW-1:0] DEPTH_L = LW'(MEMORY_DEPTH);
    localparam logic [LW-1:0] CNT_WRAP = LW'(MEMORY_DEPTH - cdte_pkg::COUNTER_WRAP_OFFSET);
    localparam logic signed [ENTRY_BITS-1:0] E_MAX = {1'b0, {(ENTRY_BITS-1){1'b1}}};
    localparam logic signed [ENTRY_BITS-1:0] E_MIN = {1'b1, {(ENTRY_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [15:0]                decay_gain_reg;
    logic [19:0]                tap_step_reg;
    logic [15:0]                second_wrap_reg;
    logic signed [15:0]         cross_level_reg;
    logic [15:0]                wet_mix_reg;
    logic [16:0]                volume_reg;

    logic signed [ENTRY_BITS-1:0] mem [MEMORY_DEPTH];
    logic [AW-1:0]              clr_addr_reg;
    logic                       clr_done_reg;

    logic [LW-1:0]              run_counter_reg;
    logic [TW-1:0]              first_tap_reg;
    logic [TW-1:0]              second_tap_reg;
    logic [LW-1:0]              delay_length_reg;
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [AW-1:0]              addr_reg;
    logic signed [ENTRY_BITS-1:0] rd_data_reg;
    logic signed [ENTRY_BITS:0] y_reg;
    logic [LW+15:0]             limit_reg;
    logic signed [MW-1:0]       mix_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic signed [ENTRY_BITS-1:0] wr_val;
    logic                       mem_we;
    logic [PW-1:0]              mag;
    logic [PW-1:0]              prod;
    logic signed [PW:0]         decayed;
    logic signed [ENTRY_BITS+1:0] summed;
    logic [TW-1:0]              ft_adv;
    logic [TW-1:0]              st_adv;
    logic [TW-1:0]              ft_next;
    logic [TW-1:0]              st_next;
    logic [TW-1:0]              top_q;
    logic [TW-1:0]              limit_c;
    logic [LW-1:0]              cnt_inc;
    logic [LW-1:0]              cnt_next;
    logic signed [17:0]         d1;
    logic signed [17:0]         d2;
    logic                       crossed;
    logic signed [MW-1:0]       mix_a;
    logic signed [VW-1:0]       vol_prod;
    logic signed [VW-1:0]       shifted;

    function automatic logic [AW-1:0] tap_idx(input logic [TW-1:0] t);
        logic [TW-17:0] ip;
        begin
            ip = t[TW-1:16];
            tap_idx = (ip < (TW-16)'(MEMORY_DEPTH)) ? ip[AW-1:0] : AW'(MEMORY_DEPTH - 1);
        end
    endfunction

    assign status.clear_done = clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_gain_reg  <= 16'd31457;
            tap_step_reg    <= 20'd26214;
            second_wrap_reg <= 16'd22938;
            cross_level_reg <= '0;
            wet_mix_reg     <= 16'd32768;
            volume_reg      <= 17'd32768;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cdte_pkg::REG_DECAY_GAIN:  decay_gain_reg  <= wr_data[15:0];
                cdte_pkg::REG_TAP_STEP:    tap_step_reg    <= wr_data;
                cdte_pkg::REG_SECOND_WRAP: second_wrap_reg <= wr_data[15:0];
                cdte_pkg::REG_CROSS_LEVEL: cross_level_reg <= wr_data[15:0];
                cdte_pkg::REG_WET_MIX:     wet_mix_reg     <= wr_data[15:0];
                cdte_pkg::REG_OUT_VOLUME:  volume_reg      <= wr_data[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mag = rd_data_reg[ENTRY_BITS-1] ? PW'(-(ENTRY_BITS+1)'(rd_data_reg))
                                        : PW'(rd_data_reg);
        prod = (mag * PW'(decay_gain_reg)) >> 15;
        decayed = rd_data_reg[ENTRY_BITS-1] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
        summed = (ENTRY_BITS+2)'(rd_data_reg) + (ENTRY_BITS+2)'(x_reg);
        ft_adv = first_tap_reg + TW'(tap_step_reg);
        st_adv = second_tap_reg + TW'(tap_step_reg);
        ft_next = (ft_adv[TW-1:16] >= (TW-16)'(delay_length_reg)) ? '0 : ft_adv;
        top_q = TW'(DEPTH_L) << 16;
        limit_c = ({1'b0, limit_reg} > (LW+17)'(top_q)) ? top_q : TW'(limit_reg);
        st_next = (st_adv >= limit_c) ? '0 : st_adv;
        cnt_inc = run_counter_reg + 1'b1;
        cnt_next = (cnt_inc >= CNT_WRAP) ? '0 : cnt_inc;
        d1 = 18'(prev_sample_reg) - 18'(cross_level_reg);
        d2 = 18'(x_reg) - 18'(cross_level_reg);
        crossed = (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);
        mix_a = MW'(x_reg) * MW'($signed({1'b0, 17'd32768} - {2'b0, wet_mix_reg}));
        vol_prod = VW'(mix_reg) * VW'($signed({1'b0, volume_reg}));
        shifted = (vol_prod + (VW'(1) <<< 29)) >>> 30;

        rd_addr = addr_reg;
        wr_addr = addr_reg;
        wr_val = rd_data_reg;
        mem_we = 1'b0;
        if (!clr_done_reg)
        begin
            wr_addr = clr_addr_reg;
            wr_val = '0;
            mem_we = 1'b1;
        end
        else if (cmd.write_first || cmd.write_second)
        begin
            mem_we = 1'b1;
            if (decayed > (PW+1)'(E_MAX))
                wr_val = E_MAX;
            else if (decayed < (PW+1)'(E_MIN))
                wr_val = E_MIN;
            else
                wr_val = decayed[ENTRY_BITS-1:0];
        end
        else if (cmd.write_new)
        begin
            mem_we = 1'b1;
            if (summed > (ENTRY_BITS+2)'(E_MAX))
                wr_val = E_MAX;
            else if (summed < (ENTRY_BITS+2)'(E_MIN))
                wr_val = E_MIN;
            else
                wr_val = summed[ENTRY_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_val;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            clr_done_reg     <= 1'b0;
            run_counter_reg  <= '0;
            first_tap_reg    <= '0;
            second_tap_reg   <= '0;
            delay_length_reg <= LW'(MEMORY_DEPTH - 1);
            prev_sample_reg  <= '0;
            x_reg            <= '0;
            addr_reg         <= '0;
            y_reg            <= '0;
            limit_reg        <= '0;
            mix_reg          <= '0;
            out_reg          <= '0;
        end
        else
        begin
            if (!clr_done_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MEMORY_DEPTH - 1))
                    clr_done_reg <= 1'b1;
            end
            if (cmd.start)
            begin
                x_reg <= sample_in;
                run_counter_reg <= cnt_next;
                addr_reg <= tap_idx(first_tap_reg);
                limit_reg <= {(LW+15)'(delay_length_reg) * (LW+15)'(second_wrap_reg), 1'b0};
            end
            if (cmd.write_first)
                y_reg <= (ENTRY_BITS+1)'(rd_data_reg);
            if (cmd.advance)
            begin
                first_tap_reg <= ft_next;
                second_tap_reg <= st_next;
                addr_reg <= tap_idx(st_next);
            end
            if (cmd.write_second)
            begin
                y_reg <= y_reg + (ENTRY_BITS+1)'(rd_data_reg);
                addr_reg <= tap_idx(first_tap_reg);
            end
            if (cmd.write_new)
            begin
                if (crossed)
                begin
                    delay_length_reg <= run_counter_reg + LW'(cdte_pkg::RETIME_OFFSET);
                    run_counter_reg <= '0;
                end
                prev_sample_reg <= x_reg;
            end
            if (cmd.mix_a)
                mix_reg <= mix_a;
            if (cmd.mix_b)
                mix_reg <= mix_reg + MW'(y_reg) * MW'($signed({1'b0, wet_mix_reg}));
            if (cmd.finish)
            begin
                if (shifted > VW'(S_MAX))
                    out_reg <= S_MAX;
                else if (shifted < VW'(S_MIN))
                    out_reg <= S_MIN;
                else
                    out_reg <= shifted[SAMPLE_BITS-1:0];
            end
        end
    end

    assign sample_out = out_reg;

endmodule

>>> design/cdte_controller.sv
// ----------------------------------------------------------------------------
// cdte_controller
// Sequences one sample at a time through the datapath and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module cdte_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  cdte_pkg::cdte_status_t status,
    output cdte_pkg::cdte_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_WR1, S_ADV, S_RD2, S_WR2, S_RDN, S_WRN, S_MIXB,
        S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd.clear_step = (state_reg == S_CLEAR);
        case (state_reg)
            S_CLEAR: if (status.clear_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1: begin cmd.read_first = 1'b1; state_next = S_WR1; end
            S_WR1: begin cmd.write_first = 1'b1; state_next = S_ADV; end
            S_ADV: begin cmd.advance = 1'b1; state_next = S_RD2; end
            S_RD2: begin cmd.read_second = 1'b1; state_next = S_WR2; end
            S_WR2: begin cmd.write_second = 1'b1; state_next = S_RDN; end
            S_RDN: begin cmd.read_new = 1'b1; cmd.mix_a = 1'b1; state_next = S_WRN; end
            S_WRN: begin cmd.write_new = 1'b1; state_next = S_MIXB; end
            S_MIXB: begin cmd.mix_b = 1'b1; state_next = S_FIN; end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (out_valid_reg && !out_stall && !cmd.finish)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/crossing_retimed_dual_tap_echo.sv
// ----------------------------------------------------------------------------
// crossing_retimed_dual_tap_echo
// Dual-tap decaying echo whose delay is retimed on input level crossings.
//
// Channel   Signals                          Direction
// input     in_valid, in_stall, sample_in    in
// output    out_valid, out_stall, sample_out out
// config    cfg_we, cfg_index, cfg_data      in
//
// Each transaction steps through the states RD1, WR1, ADV, RD2, WR2, RDN, WRN,
// MIXB and FIN from acceptance to result, and a new input is accepted only once
// the last one is back in IDLE; the memory, with three reads and three writes per
// sample, sets this pace. After reset the memory is cleared one entry per cycle,
// during which no input is accepted. A held result does not block the next input;
// only the final write of the result waits on the output stall.
// ----------------------------------------------------------------------------
module crossing_retimed_dual_tap_echo #(
    parameter int MEMORY_DEPTH = cdte_pkg::MEMORY_DEPTH_DEF,
    parameter int SAMPLE_BITS  = cdte_pkg::SAMPLE_BITS_DEF,
    parameter int ENTRY_BITS   = cdte_pkg::ENTRY_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      sample_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    input  logic                               cfg_we,
    input  logic [cdte_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [cdte_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    cdte_pkg::cdte_cmd_t    cmd;
    cdte_pkg::cdte_status_t status;

    cdte_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cdte_datapath #(
        .MEMORY_DEPTH (MEMORY_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ENTRY_BITS   (ENTRY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .wr_en      (cfg_we),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

endmodule
